>>> design/cbe_pkg.sv
// ----------------------------------------------------------------------------
// cbe_pkg
// Types, constants and helper functions of the Cheyette-beta Euler step unit.
// ----------------------------------------------------------------------------
package cbe_pkg;

    localparam int FRAC_BITS = 32;
    localparam int WORD_BITS = 48;
    localparam int INT_BITS  = WORD_BITS - FRAC_BITS;
    localparam int HALF_BITS = WORD_BITS / 2;
    localparam int MANT      = 30;
    localparam int BETA_BITS = 34;
    localparam int MODE_BITS = 2;
    localparam int STEPS     = FRAC_BITS;

    localparam int EXP_BIAS   = FRAC_BITS - MANT;
    localparam int EXP_SAT_SH = 33;

    // pipeline latencies and tap points
    localparam int MUL_LAT    = 3;
    localparam int LOG_LAT    = STEPS + 1;
    localparam int EXP_LAT    = STEPS + 1;
    localparam int T_LOG      = LOG_LAT - 1;
    localparam int T_POW      = T_LOG + MUL_LAT + EXP_LAT;
    localparam int T_VOL      = T_POW + MUL_LAT;
    localparam int T_SQ       = T_VOL + MUL_LAT;
    localparam int T_END      = T_SQ + MUL_LAT;
    localparam int SIDE_DEPTH = T_END + 1;
    localparam int VOL_DELAY  = T_END - T_VOL;

    typedef logic signed [WORD_BITS-1:0] t_word;
    typedef logic        [WORD_BITS-1:0] t_uword;
    typedef logic        [WORD_BITS-2:0] t_dt;
    typedef logic        [BETA_BITS-1:0] t_beta;
    typedef logic        [MANT:0]        t_mant;
    typedef logic        [MODE_BITS-1:0] t_mode;

    localparam t_mode MODE_CONST = t_mode'(0);
    localparam t_mode MODE_PROP  = t_mode'(1);
    localparam t_mode MODE_POWER = t_mode'(2);
    localparam int    MODE_POW_BIT = 1;

    localparam t_uword CAP_POS = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam t_uword CAP_NEG = {1'b1, {(WORD_BITS-1){1'b0}}};
    localparam t_word  WMAX    = t_word'(CAP_POS);
    localparam t_word  WMIN    = t_word'(CAP_NEG);
    localparam t_mant  ONE_M   = t_mant'(1) << MANT;
    localparam t_word  ONE_W   = t_word'(t_uword'(1) << FRAC_BITS);

    typedef struct packed {
        t_word rate_now;
        t_word phi_in;
        t_word vol_scale;
        t_beta vol_exponent;
        t_word mean_reversion;
        t_dt   step_length;
        t_word fwd_now;
        t_word fwd_next;
        logic  has_next;
    } t_in;

    typedef struct packed {
        t_word state_dev;
        t_word next_state_dev;
        t_word next_rate;
        t_word next_phi;
        t_word local_vol_out;
        t_dt   step_variance;
        logic  status;
    } t_out;

    typedef struct packed {
        t_word r;
        t_word phi;
        t_word sig;
        t_beta beta;
        t_word lam;
        t_dt   dt;
        t_word x;
        t_word f1;
        logic  nxt;
    } t_side;

    function automatic t_word sat_add(t_word a, t_word b);
        logic signed [WORD_BITS:0] s;
        s = {a[WORD_BITS-1], a} + {b[WORD_BITS-1], b};
        if (s[WORD_BITS] != s[WORD_BITS-1]) begin
            return s[WORD_BITS] ? WMIN : WMAX;
        end
        return s[WORD_BITS-1:0];
    endfunction

    function automatic t_word sat_sub(t_word a, t_word b);
        logic signed [WORD_BITS:0] s;
        s = {a[WORD_BITS-1], a} - {b[WORD_BITS-1], b};
        if (s[WORD_BITS] != s[WORD_BITS-1]) begin
            return s[WORD_BITS] ? WMIN : WMAX;
        end
        return s[WORD_BITS-1:0];
    endfunction

    function automatic t_uword mag(t_word a);
        return a[WORD_BITS-1] ? t_uword'(-a) : t_uword'(a);
    endfunction

    // k-th repeated floor square root of 2.0, Q1.MANT (elaboration only)
    function automatic t_mant exp_coef(int k);
        logic [63:0] c;
        logic [63:0] x;
        logic [63:0] r;
        logic [63:0] b;
        c = 64'd2 << MANT;
        for (int j = 0; j < k; j++) begin
            x = c << MANT;
            r = '0;
            b = 64'd1 << 62;
            for (int i = 0; i < 32; i++) begin
                if (x >= r + b) begin
                    x = x - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
            c = r;
        end
        return c[MANT:0];
    endfunction

endpackage

>>> design/cbe_in_if.sv
// ----------------------------------------------------------------------------
// cbe_in_if
// Input channel: valid/ready handshake carrying one path sample.
// ----------------------------------------------------------------------------
interface cbe_in_if import cbe_pkg::*;;
    logic valid;
    logic ready;
    t_in  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> design/cbe_out_if.sv
// ----------------------------------------------------------------------------
// cbe_out_if
// Output channel: valid/ready handshake carrying one step result.
// ----------------------------------------------------------------------------
interface cbe_out_if import cbe_pkg::*;;
    logic valid;
    logic ready;
    t_out data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> design/cheyette_beta_euler_step_unit.sv
// ----------------------------------------------------------------------------
// cheyette_beta_euler_step_unit
// Euler step of a Cheyette-beta short-rate model, one path sample per cycle while input ready is high.
//
// i_in carries one path sample per transfer (rate, phi, sigma, beta, lambda,
// dt, forward rates, has_next); o_out returns one result per sample, in order.
// i_cfg_wr_en/i_cfg_wr_data write the 2-bit model mode (reset: power-beta);
// write it only while no sample is in flight.
// Throughput: one transfer per cycle while input ready is high. The path from
// input transfer to output valid runs through the 33-stage log2 and 33-stage
// exp2 pipelines, four 3-stage multiplier levels and the output register.
// All stages advance together. When the receiver stalls, the pipeline keeps
// taking input as long as its last stage is empty; once a result sits in the
// last stage behind a held output, input ready drops and nothing moves.
// Synchronous active-low reset clears all valid bits and sets the mode to
// power-beta; payload registers are not reset.
// ----------------------------------------------------------------------------
module cheyette_beta_euler_step_unit import cbe_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_wr_en,
    input  t_mode         i_cfg_wr_data,
    cbe_in_if.sink        i_in,
    cbe_out_if.source     o_out
);

    t_mode r_mode;
    logic  r_side_v [0:SIDE_DEPTH-1];
    t_side r_side   [0:SIDE_DEPTH-1];
    t_word r_vol    [0:VOL_DELAY-1];
    logic  r_out_valid;
    t_out  r_out;

    logic   s_out_rdy;
    logic   s_en;
    t_side  n_side;
    t_out   n_out;
    t_uword s_abs_r;
    t_word  s_log;
    t_word  s_y;
    t_word  s_pow;
    t_word  s_pw;
    t_word  s_op;
    t_word  s_vmul;
    t_word  s_vol;
    t_word  s_lam2;
    t_word  s_vv;
    t_word  s_lx;
    t_word  s_lp;
    t_word  s_dt;
    t_word  s_var;
    t_word  s_mu;
    t_word  s_dd;
    t_word  s_nx;

    assign s_out_rdy  = !r_out_valid || o_out.ready;
    assign s_en       = s_out_rdy || !r_side_v[T_END];
    assign i_in.ready = s_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_POWER;
        end else if (i_cfg_wr_en) begin
            r_mode <= i_cfg_wr_data;
        end
    end

    always_comb begin
        n_side.r    = i_in.data.rate_now;
        n_side.phi  = i_in.data.phi_in;
        n_side.sig  = i_in.data.vol_scale;
        n_side.beta = i_in.data.vol_exponent;
        n_side.lam  = i_in.data.mean_reversion;
        n_side.dt   = i_in.data.step_length;
        n_side.x    = sat_sub(i_in.data.rate_now, i_in.data.fwd_now);
        n_side.f1   = i_in.data.fwd_next;
        n_side.nxt  = i_in.data.has_next;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < SIDE_DEPTH; k++) begin
                r_side_v[k] <= 1'b0;
            end
        end else if (s_en) begin
            r_side_v[0] <= i_in.valid;
            for (int k = 1; k < SIDE_DEPTH; k++) begin
                r_side_v[k] <= r_side_v[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_en) begin
            r_side[0] <= n_side;
            for (int k = 1; k < SIDE_DEPTH; k++) begin
                r_side[k] <= r_side[k-1];
            end
            r_vol[0] <= s_vol;
            for (int k = 1; k < VOL_DELAY; k++) begin
                r_vol[k] <= r_vol[k-1];
            end
        end
    end

    // power law |r|^beta
    assign s_abs_r = mag(i_in.data.rate_now);

    cbe_log2 u_log (
        .i_clk (i_clk),
        .i_en  (s_en),
        .i_a   (s_abs_r),
        .o_l   (s_log)
    );

    cbe_smul u_ymul (
        .i_clk (i_clk),
        .i_en  (s_en),
        .i_a   (s_log),
        .i_b   (t_word'({{(WORD_BITS-BETA_BITS){1'b0}}, r_side[T_LOG].beta})),
        .o_p   (s_y)
    );

    cbe_exp2 u_exp (
        .i_clk (i_clk),
        .i_en  (s_en),
        .i_y   (s_y),
        .o_pow (s_pow)
    );

    always_comb begin
        if (r_side[T_POW].r == '0) begin
            s_pw = (r_side[T_POW].beta != '0) ? '0 : ONE_W;
        end else begin
            s_pw = s_pow;
        end
        s_op = r_mode[MODE_POW_BIT] ? s_pw : r_side[T_POW].r;
    end

    cbe_smul u_vmul (
        .i_clk (i_clk),
        .i_en  (s_en),
        .i_a   (r_side[T_POW].sig),
        .i_b   (s_op),
        .o_p   (s_vmul)
    );

    assign s_vol  = (r_mode == MODE_CONST) ? r_side[T_VOL].sig : s_vmul;
    assign s_lam2 = sat_add(r_side[T_VOL].lam, r_side[T_VOL].lam);

    cbe_smul u_vv (
        .i_clk (i_clk), .i_en (s_en), .i_a (s_vol), .i_b (s_vol), .o_p (s_vv)
    );

    cbe_smul u_lx (
        .i_clk (i_clk), .i_en (s_en),
        .i_a (r_side[T_VOL].lam), .i_b (r_side[T_VOL].x), .o_p (s_lx)
    );

    cbe_smul u_lp (
        .i_clk (i_clk), .i_en (s_en),
        .i_a (s_lam2), .i_b (r_side[T_VOL].phi), .o_p (s_lp)
    );

    assign s_dt = t_word'({1'b0, r_side[T_SQ].dt});

    cbe_smul u_var (
        .i_clk (i_clk), .i_en (s_en), .i_a (s_vv), .i_b (s_dt), .o_p (s_var)
    );

    cbe_smul u_mu (
        .i_clk (i_clk), .i_en (s_en),
        .i_a (sat_sub(r_side[T_SQ].phi, s_lx)), .i_b (s_dt), .o_p (s_mu)
    );

    cbe_smul u_dd (
        .i_clk (i_clk), .i_en (s_en),
        .i_a (sat_sub(s_vv, s_lp)), .i_b (s_dt), .o_p (s_dd)
    );

    always_comb begin
        s_nx = sat_add(r_side[T_END].x, s_mu);
        n_out.state_dev     = r_side[T_END].x;
        n_out.local_vol_out = r_vol[VOL_DELAY-1];
        n_out.step_variance = s_var[WORD_BITS-1] ? '0 : s_var[WORD_BITS-2:0];
        n_out.status        = !r_side[T_END].nxt;
        if (r_side[T_END].nxt) begin
            n_out.next_state_dev = s_nx;
            n_out.next_rate      = sat_add(r_side[T_END].f1, s_nx);
            n_out.next_phi       = sat_add(r_side[T_END].phi, s_dd);
        end else begin
            n_out.next_state_dev = '0;
            n_out.next_rate      = '0;
            n_out.next_phi       = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_out_rdy) begin
            r_out_valid <= r_side_v[T_END];
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_out_rdy) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    a_no_next_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.data.status |->
            o_out.data.next_phi == '0 && o_out.data.next_state_dev == '0 &&
            o_out.data.next_rate == '0)
        else $error("drift outputs not zero without next step");

    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !o_out.ready && r_side_v[T_END] |-> !i_in.ready)
        else $error("input accepted while pipeline is blocked");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out.valid && !r_side_v[0] && !r_side_v[T_END])
        else $error("valid bits not cleared by reset");

endmodule

>>> design/cbe_smul.sv
// ----------------------------------------------------------------------------
// cbe_smul
// Three-stage signed fixed-point multiply: magnitudes, four half-width partial
// products, then sum, truncate toward zero, saturate and restore sign.
// ----------------------------------------------------------------------------
module cbe_smul import cbe_pkg::*; (
    input  logic  i_clk,
    input  logic  i_en,
    input  t_word i_a,
    input  t_word i_b,
    output t_word o_p
);

    logic   r_neg_a;
    t_uword r_ma;
    t_uword r_mb;
    logic   r_neg_b;
    t_uword r_p00;
    t_uword r_p01;
    t_uword r_p10;
    t_uword r_p11;
    t_word  r_p;

    logic [2*WORD_BITS-1:0] s_prod;
    logic [63:0]            s_r;
    t_uword                 s_cap;
    t_uword                 s_mag;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_neg_a <= i_a[WORD_BITS-1] ^ i_b[WORD_BITS-1];
            r_ma    <= mag(i_a);
            r_mb    <= mag(i_b);
            r_neg_b <= r_neg_a;
            r_p00   <= r_ma[HALF_BITS-1:0] * r_mb[HALF_BITS-1:0];
            r_p01   <= r_ma[HALF_BITS-1:0] * r_mb[WORD_BITS-1:HALF_BITS];
            r_p10   <= r_ma[WORD_BITS-1:HALF_BITS] * r_mb[HALF_BITS-1:0];
            r_p11   <= r_ma[WORD_BITS-1:HALF_BITS] * r_mb[WORD_BITS-1:HALF_BITS];
            r_p     <= r_neg_b ? -t_word'(s_mag) : t_word'(s_mag);
        end
    end

    always_comb begin
        s_prod = {r_p11, {WORD_BITS{1'b0}}}
               + {{HALF_BITS{1'b0}}, r_p01, {HALF_BITS{1'b0}}}
               + {{HALF_BITS{1'b0}}, r_p10, {HALF_BITS{1'b0}}}
               + {{WORD_BITS{1'b0}}, r_p00};
        s_r    = 64'(s_prod >> FRAC_BITS);
        s_cap  = r_neg_b ? CAP_NEG : CAP_POS;
        s_mag  = (s_r > 64'(s_cap)) ? s_cap : s_r[WORD_BITS-1:0];
    end

    assign o_p = r_p;

endmodule

>>> design/cbe_log2.sv
// ----------------------------------------------------------------------------
// cbe_log2
// Pipelined log2 of a nonzero magnitude: one normalize stage, then one
// square-and-compare stage per fraction bit.
// ----------------------------------------------------------------------------
module cbe_log2 import cbe_pkg::*; (
    input  logic   i_clk,
    input  logic   i_en,
    input  t_uword i_a,
    output t_word  o_l
);

    t_mant                       r_m  [0:STEPS];
    logic [FRAC_BITS-1:0]        r_fr [0:STEPS];
    logic signed [INT_BITS-1:0]  r_e  [0:STEPS];

    logic [5:0] s_msb;
    t_uword     s_norm;

    always_comb begin
        s_msb = '0;
        for (int i = 0; i < WORD_BITS; i++) begin
            if (i_a[i]) begin
                s_msb = 6'(i);
            end
        end
        s_norm = i_a << (6'(WORD_BITS - 1) - s_msb);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m[0]  <= s_norm[WORD_BITS-1 -: MANT+1];
            r_fr[0] <= '0;
            r_e[0]  <= INT_BITS'(s_msb) - INT_BITS'(FRAC_BITS);
        end
    end

    for (genvar k = 1; k <= STEPS; k++) begin : g_step
        logic [2*MANT+1:0] s_sq;
        logic [MANT+1:0]   s_t;

        always_comb begin
            s_sq = r_m[k-1] * r_m[k-1];
            s_t  = s_sq[2*MANT+1:MANT];
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_m[k]  <= s_t[MANT+1] ? s_t[MANT+1:1] : s_t[MANT:0];
                r_fr[k] <= {r_fr[k-1][FRAC_BITS-2:0], s_t[MANT+1]};
                r_e[k]  <= r_e[k-1];
            end
        end
    end

    assign o_l = {r_e[STEPS], r_fr[STEPS]};

endmodule

>>> design/cbe_exp2.sv
// ----------------------------------------------------------------------------
// cbe_exp2
// Pipelined 2^y: one conditional multiply by a root-of-two constant per
// fraction bit, then a saturating shift by the integer part.
// ----------------------------------------------------------------------------
module cbe_exp2 import cbe_pkg::*; (
    input  logic  i_clk,
    input  logic  i_en,
    input  t_word i_y,
    output t_word o_pow
);

    t_mant                      r_p [0:STEPS-1];
    logic [FRAC_BITS-1:0]       r_f [0:STEPS-1];
    logic signed [INT_BITS-1:0] r_n [0:STEPS-1];
    t_word                      r_pow;

    for (genvar k = 0; k < STEPS; k++) begin : g_step
        localparam t_mant C_K = exp_coef(k + 1);
        t_mant                      s_p_in;
        logic [FRAC_BITS-1:0]       s_f_in;
        logic signed [INT_BITS-1:0] s_n_in;
        logic [2*MANT+1:0]          s_pr;

        if (k == 0) begin : g_first
            assign s_p_in = ONE_M;
            assign s_f_in = i_y[FRAC_BITS-1:0];
            assign s_n_in = i_y[WORD_BITS-1:FRAC_BITS];
        end else begin : g_next
            assign s_p_in = r_p[k-1];
            assign s_f_in = r_f[k-1];
            assign s_n_in = r_n[k-1];
        end

        assign s_pr = s_p_in * C_K;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_p[k] <= s_f_in[FRAC_BITS-1-k] ? s_pr[2*MANT:MANT] : s_p_in;
                r_f[k] <= s_f_in;
                r_n[k] <= s_n_in;
            end
        end
    end

    logic signed [INT_BITS:0] s_sh;
    logic signed [INT_BITS:0] s_nsh;
    logic [63:0]              s_v;
    t_word                    s_pow;

    always_comb begin
        s_sh  = {r_n[STEPS-1][INT_BITS-1], r_n[STEPS-1]} + (INT_BITS+1)'(EXP_BIAS);
        s_nsh = -s_sh;
        s_v   = 64'(r_p[STEPS-1]) << s_sh[5:0];
        if (s_sh >= (INT_BITS+1)'(EXP_SAT_SH)) begin
            s_pow = WMAX;
        end else if (s_sh >= 0) begin
            s_pow = (s_v > 64'(CAP_POS)) ? WMAX : t_word'(s_v[WORD_BITS-1:0]);
        end else if (s_nsh > (INT_BITS+1)'(MANT)) begin
            s_pow = '0;
        end else begin
            s_pow = t_word'(r_p[STEPS-1] >> s_nsh[4:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pow <= s_pow;
        end
    end

    assign o_pow = r_pow;

endmodule

>>> tb/cheyette_beta_euler_step_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cheyette_beta_euler_step_unit_tb
// Self-checking bench for the Cheyette-beta Euler step unit. Path samples are
// driven over the input channel, in some phases under random sender gaps and receiver stalls.
// A bit-exact fixed-point predictor (saturating arithmetic, iterative log2 and
// exp2) computes each step result and the returned transfers are compared in
// order. The model mode is changed between drained phases and covers 0 to 3.
// ----------------------------------------------------------------------------
module cheyette_beta_euler_step_unit_tb import cbe_pkg::*;;

    localparam longint W_HI  = (64'sd1 <<< 47) - 1;
    localparam longint W_LO  = -(64'sd1 <<< 47);
    localparam int     DRAIN = 100;
    localparam int     LIMIT = 600000;

    class step_scoreboard;
        t_out       step_q[$];
        t_mode      mode;
        logic [63:0] sqrt2_tab[0:32];
        int         mismatches;
        int         checked;
        int         mode_hits[4];

        function new();
            mode = MODE_POWER;
            sqrt2_tab[0] = 64'd2 << 30;
            for (int k = 1; k <= 32; k++) sqrt2_tab[k] = floor_sqrt(sqrt2_tab[k-1] << 30);
        endfunction

        function logic [63:0] floor_sqrt(logic [63:0] x);
            logic [63:0] r;
            logic [63:0] b;
            r = 0;
            b = 64'd1 << 62;
            while (b > x) b = b >> 2;
            while (b != 0) begin
                if (x >= r + b) begin
                    x = x - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
            return r;
        endfunction

        function longint clamp(longint v);
            if (v > W_HI) return W_HI;
            if (v < W_LO) return W_LO;
            return v;
        endfunction

        function logic [63:0] absval(longint a);
            return a < 0 ? 64'(-a) : 64'(a);
        endfunction

        function logic [63:0] prod_shift(logic [63:0] a, logic [63:0] b, logic [63:0] cap);
            logic [127:0] p;
            p = 128'(a) * 128'(b);
            p = p >> 32;
            return (p > 128'(cap)) ? cap : p[63:0];
        endfunction

        function longint fx_mul(longint a, longint b);
            bit          neg;
            logic [63:0] r;
            neg = (a < 0) != (b < 0);
            r = prod_shift(absval(a), absval(b), neg ? 64'(W_HI) + 1 : 64'(W_HI));
            return neg ? -longint'(r) : longint'(r);
        endfunction

        function longint fx_log2(logic [63:0] a);
            int          p;
            logic [63:0] m;
            logic [63:0] fr;
            p = 63;
            fr = 0;
            while (!a[p]) p--;
            m = (p >= 30) ? (a >> (p - 30)) : (a << (30 - p));
            for (int k = 0; k < 32; k++) begin
                m = (m * m) >> 30;
                fr = fr << 1;
                if (m >= (64'd2 << 30)) begin
                    fr = fr | 1;
                    m = m >> 1;
                end
            end
            return longint'(p - 32) * (64'sd1 <<< 32) + longint'(fr);
        endfunction

        function longint fx_exp2(longint y);
            logic [31:0] f;
            logic [63:0] p;
            logic [63:0] v;
            longint      n;
            longint      sh;
            f = y[31:0];
            p = 64'd1 << 30;
            if (y >= 0) n = y >>> 32;
            else n = -longint'((64'(-y) + 64'hFFFF_FFFF) >> 32);
            for (int k = 1; k <= 32; k++)
                if (f[32-k]) p = (p * sqrt2_tab[k]) >> 30;
            sh = n + 2;
            if (sh >= 33) return W_HI;
            if (sh >= 0) begin
                v = p << sh;
                return (v > 64'(W_HI)) ? W_HI : longint'(v);
            end
            if (-sh >= 63) return 0;
            return longint'(p >> (-sh));
        endfunction

        function longint rate_power(longint r, logic [63:0] beta);
            longint      l;
            logic [63:0] ym;
            if (r == 0) return (beta != 0) ? 0 : (64'sd1 <<< 32);
            l = fx_log2(absval(r));
            ym = prod_shift(absval(l), beta, 64'd1 << 62);
            return fx_exp2(l < 0 ? -longint'(ym) : longint'(ym));
        endfunction

        function void note_input(t_in s);
            longint r, phi, sig, lam, dt, f0, f1, vol, x, vv, var_dt, mu, dphi, nx;
            t_out   e;
            r = s.rate_now;  phi = s.phi_in;  sig = s.vol_scale;
            lam = s.mean_reversion;  dt = longint'({1'b0, s.step_length});
            f0 = s.fwd_now;  f1 = s.fwd_next;
            if (mode[1]) vol = fx_mul(sig, rate_power(r, 64'(s.vol_exponent)));
            else if (mode[0]) vol = fx_mul(sig, r);
            else vol = sig;
            x = clamp(r - f0);
            vv = fx_mul(vol, vol);
            var_dt = fx_mul(vv, dt);
            if (var_dt < 0) var_dt = 0;
            e = '0;
            e.state_dev = t_word'(x);
            e.local_vol_out = t_word'(vol);
            e.step_variance = t_dt'(var_dt);
            e.status = !s.has_next;
            if (s.has_next) begin
                mu = fx_mul(clamp(phi - fx_mul(lam, x)), dt);
                dphi = clamp(vv - fx_mul(clamp(lam + lam), phi));
                nx = clamp(x + mu);
                e.next_state_dev = t_word'(nx);
                e.next_rate = t_word'(clamp(f1 + nx));
                e.next_phi = t_word'(clamp(phi + fx_mul(dphi, dt)));
            end
            mode_hits[mode]++;
            step_q.push_back(e);
        endfunction

        function bit field_ok(string name, logic [63:0] e, logic [63:0] a);
            if (a === e) return 1;
            if (mismatches < 10)
                $display("mismatch %0s: expected %h got %h", name, e, a);
            return 0;
        endfunction

        function void check_result(t_out a);
            t_out e;
            bit   ok;
            if (step_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result transfer %h", a);
                return;
            end
            e = step_q.pop_front();
            checked++;
            ok = field_ok("state_dev", 64'(e.state_dev), 64'(a.state_dev));
            ok &= field_ok("next_state_dev", 64'(e.next_state_dev), 64'(a.next_state_dev));
            ok &= field_ok("next_rate", 64'(e.next_rate), 64'(a.next_rate));
            ok &= field_ok("next_phi", 64'(e.next_phi), 64'(a.next_phi));
            ok &= field_ok("local_vol_out", 64'(e.local_vol_out), 64'(a.local_vol_out));
            ok &= field_ok("step_variance", 64'(e.step_variance), 64'(a.step_variance));
            ok &= field_ok("status", 64'(e.status), 64'(a.status));
            if (!ok) mismatches++;
        endfunction

        function int pending();
            return step_q.size();
        endfunction
    endclass

    logic  i_clk;
    logic  i_rst_n;
    logic  i_cfg_wr_en;
    t_mode i_cfg_wr_data;
    int    snd_idle;
    int    rcv_idle;
    int    cycles;

    cbe_in_if  in_if();
    cbe_out_if out_if();

    step_scoreboard sb;

    cheyette_beta_euler_step_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in          (in_if),
        .o_out         (out_if)
    );

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready) sb.check_result(out_if.data);
        out_if.ready <= ($urandom_range(0, 99) >= rcv_idle);
    end

    function automatic t_word rand_word();
        longint v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: v = longint'({$urandom, $urandom});
            4, 5, 6, 7: begin
                v = longint'($urandom) << $urandom_range(0, 3);
                if ($urandom_range(0, 1)) v = -v;
            end
            8:       v = 0;
            default: case ($urandom_range(0, 3))
                0: v = W_HI;
                1: v = W_LO;
                2: v = 1;
                default: v = -1;
            endcase
        endcase
        return t_word'(v);
    endfunction

    function automatic t_in rand_sample();
        t_in s;
        s.rate_now = rand_word();
        s.phi_in = rand_word();
        s.vol_scale = rand_word();
        s.mean_reversion = rand_word();
        s.fwd_now = rand_word();
        s.fwd_next = rand_word();
        case ($urandom_range(0, 9))
            0:       s.vol_exponent = '0;
            1:       s.vol_exponent = t_beta'(64'd1 << 33);
            2:       s.vol_exponent = t_beta'({$urandom, $urandom});
            default: s.vol_exponent = t_beta'($urandom_range(0, 2)) << 32 | t_beta'($urandom);
        endcase
        if (s.vol_exponent > t_beta'(64'd1 << 33) && $urandom_range(0, 3) != 0)
            s.vol_exponent = t_beta'(64'd1 << 33);
        case ($urandom_range(0, 7))
            0:       s.step_length = t_dt'({$urandom, $urandom});
            1:       s.step_length = '0;
            default: s.step_length = t_dt'($urandom);
        endcase
        s.has_next = ($urandom_range(0, 4) != 0);
        return s;
    endfunction

    task automatic send_sample(t_in s);
        if ($urandom_range(0, 99) < snd_idle) begin
            in_if.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < snd_idle);
        end
        in_if.valid <= 1'b1;
        in_if.data <= s;
        do @(posedge i_clk); while (!in_if.ready);
        sb.note_input(s);
    endtask

    task automatic drain();
        in_if.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    task automatic write_mode(t_mode m);
        drain();
        repeat (DRAIN) @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= m;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        sb.mode = m;
    endtask

    task automatic send_directed();
        t_in s;
        for (int i = 0; i < 18; i++) begin
            s = '0;
            s.vol_scale = t_word'(64'd1 << 32);
            s.step_length = t_dt'(64'd1 << 28);
            s.vol_exponent = t_beta'(64'd1 << 31);
            s.has_next = 1'b1;
            case (i)
                0: s.vol_exponent = '0;
                1: ;
                2: s.rate_now = t_word'(-(64'sd3 <<< 30));
                3: s.rate_now = t_word'(64'sd5 <<< 29);
                4: s.rate_now = WMAX;
                5: s.rate_now = WMIN;
                6: begin
                    s.rate_now = WMAX; s.phi_in = WMAX; s.vol_scale = WMAX;
                    s.mean_reversion = WMAX; s.fwd_now = WMIN; s.fwd_next = WMAX;
                    s.step_length = '1; s.vol_exponent = t_beta'(64'd1 << 33);
                end
                7: begin
                    s.rate_now = WMIN; s.phi_in = WMIN; s.vol_scale = WMIN;
                    s.mean_reversion = WMIN; s.fwd_now = WMAX; s.fwd_next = WMIN;
                    s.step_length = '1;
                end
                8: begin
                    s.rate_now = t_word'(64'sd1 <<< 30); s.has_next = 1'b0;
                    s.phi_in = WMAX;
                end
                9: begin s.rate_now = t_word'(64'sd1); s.step_length = '0; end
                10: begin s.rate_now = t_word'(-64'sd1); s.vol_exponent = '1; end
                11: begin
                    s.rate_now = t_word'(64'sd7 <<< 32);
                    s.vol_exponent = t_beta'(64'd1 << 33);
                end
                12: begin
                    s.rate_now = t_word'(64'sd1 <<< 20);
                    s.vol_exponent = t_beta'(64'd3 << 32);
                end
                13: begin s.vol_exponent = '1; s.rate_now = t_word'(64'sd2 <<< 32); end
                14: begin s.rate_now = t_word'(64'sd1 <<< 32); s.vol_scale = '0; end
                15: s = '0;
                16: begin s = '1; s.has_next = 1'b0; end
                default: s = rand_sample();
            endcase
            send_sample(s);
        end
    endtask

    initial begin
        t_mode modes[6];
        sb = new();
        snd_idle = 0;
        rcv_idle = 0;
        i_rst_n <= 1'b0;
        i_cfg_wr_en <= 1'b0;
        i_cfg_wr_data <= MODE_CONST;
        in_if.valid <= 1'b0;
        in_if.data <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_directed();

        modes = '{MODE_POWER, MODE_CONST, t_mode'(3), MODE_PROP, MODE_POWER, t_mode'(3)};
        for (int ph = 0; ph < 6; ph++) begin
            if (ph > 0) write_mode(modes[ph]);
            case (ph / 2)
                0: begin snd_idle = 28; rcv_idle = 64; end
                1: begin snd_idle = 64; rcv_idle = 28; end
                default: begin snd_idle = 0; rcv_idle = 0; end
            endcase
            for (int n = 0; n < 300; n++) begin
                if (ph == 1 && n == 150) drain();
                send_sample(rand_sample());
            end
        end

        drain();
        repeat (DRAIN) @(posedge i_clk);
        $display("covered %0d results; per mode 0..3: %0d %0d %0d %0d",
                 sb.checked, sb.mode_hits[0], sb.mode_hits[1], sb.mode_hits[2],
                 sb.mode_hits[3]);
        $display("mismatches %0d, outstanding %0d", sb.mismatches, sb.pending());
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

>>> files.f
design/cbe_pkg.sv
design/cbe_in_if.sv
design/cbe_out_if.sv
design/cbe_smul.sv
design/cbe_log2.sv
design/cbe_exp2.sv
design/cheyette_beta_euler_step_unit.sv
tb/cheyette_beta_euler_step_unit_tb.sv
